>>> hw/rtl/fdtd_pkg.sv
// shared types, constants and helpers for the 1-d yee grid step unit
package fdtd_pkg;

    localparam int NCELLS     = 256;
    localparam int DATA_W     = 32;
    localparam int PIPE_DEPTH = 3;
    localparam int PASS_LEN   = NCELLS + PIPE_DEPTH;
    localparam int CNT_W      = $clog2(PASS_LEN);
    localparam int DIFF_W     = DATA_W + 1;
    localparam int COEF_W     = 25;
    localparam int PROD_W     = DIFF_W + COEF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_W     = 24;

    localparam int SRC_CELL_W = 8;
    localparam int IMP_W      = 10;
    localparam int INV_IMP_W  = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SRC_CELL_W-1:0] SRC_CELL_RST = 8'd50;
    localparam logic [IMP_W-1:0]      IMP_RST      = 10'd377;
    localparam logic [INV_IMP_W-1:0]  INV_IMP_RST  = 24'd44502;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CELL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMPEDANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_IMP     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HPASS,
        ST_EPASS,
        ST_RPASS,
        ST_RHOLD
    } state_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_H,
        MODE_E
    } upd_mode_t;

    typedef struct packed {
        upd_mode_t mode;
        logic      copy;
        logic      src_hit;
    } upd_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] max_v;
        logic signed [SUM_W-1:0] min_v;
        max_v = SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        min_v = SUM_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
        if (v > max_v)
        begin
            return max_v[DATA_W-1:0];
        end
        else if (v < min_v)
        begin
            return min_v[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

>>> hw/rtl/fdtd_cell.sv
// one grid cell of the ring: holds ez and hy, takes its neighbor's values on shift
module fdtd_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic signed [fdtd_pkg::DATA_W-1:0]  ez_in,
    input  logic signed [fdtd_pkg::DATA_W-1:0]  hy_in,
    output logic signed [fdtd_pkg::DATA_W-1:0]  ez,
    output logic signed [fdtd_pkg::DATA_W-1:0]  hy
);

    logic signed [fdtd_pkg::DATA_W-1:0] ez_reg;
    logic signed [fdtd_pkg::DATA_W-1:0] hy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ez_reg <= '0;
            hy_reg <= '0;
        end
        else if (shift)
        begin
            ez_reg <= ez_in;
            hy_reg <= hy_in;
        end
    end

    assign ez = ez_reg;
    assign hy = hy_reg;

endmodule

>>> hw/rtl/fdtd_upd.sv
// three-stage update unit sitting in the ring between the front and the back cell
module fdtd_upd (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     shift,
    input  fdtd_pkg::upd_ctrl_t                      ctrl,
    input  logic signed [fdtd_pkg::DATA_W-1:0]       ez_in,
    input  logic signed [fdtd_pkg::DATA_W-1:0]       hy_in,
    input  logic signed [fdtd_pkg::DATA_W-1:0]       ez_nbr,
    input  logic        [fdtd_pkg::IMP_W-1:0]        impedance,
    input  logic        [fdtd_pkg::INV_IMP_W-1:0]    inverse_impedance,
    input  logic signed [fdtd_pkg::DATA_W-1:0]       source_value,
    output logic signed [fdtd_pkg::DATA_W-1:0]       ez_out,
    output logic signed [fdtd_pkg::DATA_W-1:0]       hy_out
);

    localparam int DW = fdtd_pkg::DATA_W;

    // stage 1: difference and product
    logic signed [fdtd_pkg::DIFF_W-1:0] diff_c;
    logic signed [fdtd_pkg::COEF_W-1:0] coef_c;
    logic signed [fdtd_pkg::PROD_W-1:0] prod_c;
    logic signed [DW-1:0]               copy_c;

    logic signed [DW-1:0]               prev_hy_reg;
    logic signed [fdtd_pkg::PROD_W-1:0] s1_prod_reg;
    logic signed [DW-1:0]               s1_ez_reg;
    logic signed [DW-1:0]               s1_hy_reg;
    logic signed [DW-1:0]               s1_copy_reg;
    fdtd_pkg::upd_ctrl_t                s1_ctrl_reg;

    // stage 2: accumulate and saturate
    logic signed [fdtd_pkg::PROD_W-1:0] rnd_c;
    logic signed [fdtd_pkg::PROD_W-1:0] inc_c;
    logic signed [fdtd_pkg::SUM_W-1:0]  sum_c;
    logic signed [DW-1:0]               sat_c;
    logic signed [DW-1:0]               ez2_c;
    logic signed [DW-1:0]               hy2_c;

    logic signed [DW-1:0]               s2_ez_reg;
    logic signed [DW-1:0]               s2_hy_reg;
    fdtd_pkg::upd_ctrl_t                s2_ctrl_reg;

    // stage 3: source injection
    logic signed [fdtd_pkg::SUM_W-1:0]  src_sum_c;
    logic signed [DW-1:0]               ez3_c;

    logic signed [DW-1:0]               s3_ez_reg;
    logic signed [DW-1:0]               s3_hy_reg;

    always_comb
    begin
        if (ctrl.mode == fdtd_pkg::MODE_H)
        begin
            diff_c = fdtd_pkg::DIFF_W'(ez_nbr) - fdtd_pkg::DIFF_W'(ez_in);
            coef_c = $signed(fdtd_pkg::COEF_W'(inverse_impedance));
            copy_c = prev_hy_reg;
        end
        else
        begin
            diff_c = fdtd_pkg::DIFF_W'(hy_in) - fdtd_pkg::DIFF_W'(prev_hy_reg);
            coef_c = $signed(fdtd_pkg::COEF_W'(impedance));
            copy_c = ez_nbr;
        end
        prod_c = diff_c * coef_c;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prev_hy_reg <= hy_in;
            s1_prod_reg <= prod_c;
            s1_ez_reg   <= ez_in;
            s1_hy_reg   <= hy_in;
            s1_copy_reg <= copy_c;
            s2_ez_reg   <= ez2_c;
            s2_hy_reg   <= hy2_c;
            s3_ez_reg   <= ez3_c;
            s3_hy_reg   <= s2_hy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else if (shift)
        begin
            s1_ctrl_reg <= ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_comb
    begin
        // round to nearest, ties up: add half an lsb then floor-shift
        rnd_c = (s1_prod_reg + fdtd_pkg::PROD_W'(1 << (fdtd_pkg::FRAC_W - 1)))
                >>> fdtd_pkg::FRAC_W;
        if (s1_ctrl_reg.mode == fdtd_pkg::MODE_H)
        begin
            inc_c = rnd_c;
            sum_c = fdtd_pkg::SUM_W'(s1_hy_reg) + fdtd_pkg::SUM_W'(inc_c);
        end
        else
        begin
            inc_c = s1_prod_reg;
            sum_c = fdtd_pkg::SUM_W'(s1_ez_reg) + fdtd_pkg::SUM_W'(inc_c);
        end
        sat_c = fdtd_pkg::sat32(sum_c);

        ez2_c = s1_ez_reg;
        hy2_c = s1_hy_reg;
        case (s1_ctrl_reg.mode)
            fdtd_pkg::MODE_H:
            begin
                hy2_c = s1_ctrl_reg.copy ? s1_copy_reg : sat_c;
            end
            fdtd_pkg::MODE_E:
            begin
                ez2_c = s1_ctrl_reg.copy ? s1_copy_reg : sat_c;
            end
            default:
            begin
                ez2_c = s1_ez_reg;
            end
        endcase
    end

    always_comb
    begin
        src_sum_c = fdtd_pkg::SUM_W'(s2_ez_reg) + fdtd_pkg::SUM_W'(source_value);
        if (s2_ctrl_reg.mode == fdtd_pkg::MODE_E && s2_ctrl_reg.src_hit)
        begin
            ez3_c = fdtd_pkg::sat32(src_sum_c);
        end
        else
        begin
            ez3_c = s2_ez_reg;
        end
    end

    assign ez_out = s3_ez_reg;
    assign hy_out = s3_hy_reg;

endmodule

>>> hw/rtl/fdtd_1d_yee_grid_step_unit.sv
// top level: ring of grid cells, update unit, sequencer and host ports
//
//  channel | signals                              | transaction when
//  --------+--------------------------------------+---------------------------
//  input   | in_valid in_stall cmd source_value   | in_valid && !in_stall
//          | cell_index                           |
//  output  | out_valid out_stall read_index       | out_valid && !out_stall
//          | ez_value hy_value                    |
//  config  | cfg_valid cfg_ready cfg_index        | cfg_valid && cfg_ready
//          | cfg_data                             |
//
//  a step rotates the grid twice through the single three-stage update unit, hy then ez,
//  with in_stall high through both passes; the next item is taken back in idle
//  a read rotates once, then waits in a hold state until the output register is free
//  and loads it; in_stall stays high until that load
//  reset clears every cell at once; no clearing pass
//  a result waits in the output register under out_stall while the next item is taken
module fdtd_1d_yee_grid_step_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     cmd,
    input  logic signed [31:0]                       source_value,
    input  logic        [7:0]                        cell_index,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic        [7:0]                        read_index,
    output logic signed [31:0]                       ez_value,
    output logic signed [31:0]                       hy_value,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [fdtd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic        [fdtd_pkg::INV_IMP_W-1:0]    cfg_data
);

    localparam int N  = fdtd_pkg::NCELLS;
    localparam int DW = fdtd_pkg::DATA_W;
    localparam int CW = fdtd_pkg::CNT_W;

    fdtd_pkg::state_t state_reg;
    fdtd_pkg::state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          pass_end;

    logic [fdtd_pkg::SRC_CELL_W-1:0] source_cell_reg;
    logic [fdtd_pkg::IMP_W-1:0]      impedance_reg;
    logic [fdtd_pkg::INV_IMP_W-1:0]  inv_imp_reg;

    logic signed [DW-1:0] src_reg;
    logic        [7:0]    idx_reg;
    logic signed [DW-1:0] rd_ez_reg;
    logic signed [DW-1:0] rd_hy_reg;

    logic                 out_valid_reg;
    logic        [7:0]    read_index_reg;
    logic signed [DW-1:0] ez_value_reg;
    logic signed [DW-1:0] hy_value_reg;

    logic                 accept;
    logic                 out_load;
    logic                 shift;
    logic                 in_stall_c;
    fdtd_pkg::upd_ctrl_t  ctrl;

    logic signed [DW-1:0] cell_ez [N];
    logic signed [DW-1:0] cell_hy [N];
    logic signed [DW-1:0] upd_ez;
    logic signed [DW-1:0] upd_hy;

    // ring: each cell takes from the one behind it, the back cell from the update unit
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        if (k == N - 1)
        begin : g_back
            fdtd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .ez_in (upd_ez),
                .hy_in (upd_hy),
                .ez    (cell_ez[k]),
                .hy    (cell_hy[k])
            );
        end
        else
        begin : g_mid
            fdtd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .ez_in (cell_ez[k+1]),
                .hy_in (cell_hy[k+1]),
                .ez    (cell_ez[k]),
                .hy    (cell_hy[k])
            );
        end
    end

    fdtd_upd u_upd (
        .clk               (clk),
        .rst_n             (rst_n),
        .shift             (shift),
        .ctrl              (ctrl),
        .ez_in             (cell_ez[0]),
        .hy_in             (cell_hy[0]),
        .ez_nbr            (cell_ez[1]),
        .impedance         (impedance_reg),
        .inverse_impedance (inv_imp_reg),
        .source_value      (src_reg),
        .ez_out            (upd_ez),
        .hy_out            (upd_hy)
    );

    assign accept   = in_valid && !in_stall_c;
    assign pass_end = (count_reg == CW'(fdtd_pkg::PASS_LEN - 1));
    assign out_load = (state_reg == fdtd_pkg::ST_RHOLD) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdtd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cmd ? fdtd_pkg::ST_RPASS : fdtd_pkg::ST_HPASS;
                end
            end
            fdtd_pkg::ST_HPASS:
            begin
                if (pass_end)
                begin
                    state_next = fdtd_pkg::ST_EPASS;
                end
            end
            fdtd_pkg::ST_EPASS:
            begin
                if (pass_end)
                begin
                    state_next = fdtd_pkg::ST_IDLE;
                end
            end
            fdtd_pkg::ST_RPASS:
            begin
                if (pass_end)
                begin
                    state_next = fdtd_pkg::ST_RHOLD;
                end
            end
            fdtd_pkg::ST_RHOLD:
            begin
                if (out_load)
                begin
                    state_next = fdtd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdtd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall_c   = 1'b1;
        shift        = 1'b0;
        ctrl.mode    = fdtd_pkg::MODE_PASS;
        ctrl.copy    = 1'b0;
        ctrl.src_hit = 1'b0;
        count_next   = '0;
        unique case (state_reg)
            fdtd_pkg::ST_IDLE:
            begin
                in_stall_c = 1'b0;
            end
            fdtd_pkg::ST_HPASS:
            begin
                shift      = 1'b1;
                ctrl.mode  = fdtd_pkg::MODE_H;
                // last hy cell takes the old value of its left neighbor
                ctrl.copy  = (count_reg == CW'(N - 1));
                count_next = pass_end ? '0 : count_reg + 1'b1;
            end
            fdtd_pkg::ST_EPASS:
            begin
                shift        = 1'b1;
                ctrl.mode    = fdtd_pkg::MODE_E;
                ctrl.copy    = (count_reg == '0);
                ctrl.src_hit = (32'(count_reg) == 32'(source_cell_reg))
                               && (32'(source_cell_reg) < 32'(N));
                count_next   = pass_end ? '0 : count_reg + 1'b1;
            end
            fdtd_pkg::ST_RPASS:
            begin
                shift      = 1'b1;
                count_next = pass_end ? '0 : count_reg + 1'b1;
            end
            fdtd_pkg::ST_RHOLD:
            begin
                in_stall_c = 1'b1;
            end
            default:
            begin
                in_stall_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdtd_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // item payload and read capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg   <= source_value;
            idx_reg   <= cell_index;
            rd_ez_reg <= '0;
            rd_hy_reg <= '0;
        end
        else if (state_reg == fdtd_pkg::ST_RPASS
                 && 32'(count_reg) == 32'(idx_reg)
                 && 32'(idx_reg) < 32'(N))
        begin
            rd_ez_reg <= cell_ez[0];
            rd_hy_reg <= cell_hy[0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_index_reg <= idx_reg;
            ez_value_reg   <= rd_ez_reg;
            hy_value_reg   <= rd_hy_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_cell_reg <= fdtd_pkg::SRC_CELL_RST;
            impedance_reg   <= fdtd_pkg::IMP_RST;
            inv_imp_reg     <= fdtd_pkg::INV_IMP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fdtd_pkg::REG_SOURCE_CELL:
                begin
                    source_cell_reg <= cfg_data[fdtd_pkg::SRC_CELL_W-1:0];
                end
                fdtd_pkg::REG_IMPEDANCE:
                begin
                    impedance_reg <= cfg_data[fdtd_pkg::IMP_W-1:0];
                end
                fdtd_pkg::REG_INV_IMP:
                begin
                    inv_imp_reg <= cfg_data[fdtd_pkg::INV_IMP_W-1:0];
                end
                default:
                begin
                    inv_imp_reg <= inv_imp_reg;
                end
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign in_stall   = in_stall_c;
    assign out_valid  = out_valid_reg;
    assign read_index = read_index_reg;
    assign ez_value   = ez_value_reg;
    assign hy_value   = hy_value_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != fdtd_pkg::ST_IDLE))
        else $error("accepted transaction did not start a pass");

    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == fdtd_pkg::ST_RHOLD))
        else $error("result appeared without a finished read");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> (count_reg <= CW'(fdtd_pkg::PASS_LEN - 1)))
        else $error("pass counter ran past one rotation");

    a_ring_still_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdtd_pkg::ST_IDLE || state_reg == fdtd_pkg::ST_RHOLD) |-> !shift)
        else $error("ring rotated outside a pass");

endmodule

>>> sim/fdtd_grid_checker.sv
// checker for the yee grid step unit: mirrors both field arrays, compares read transactions
`timescale 1ns / 100ps
module fdtd_grid_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [31:0]                   source_value,
    input  logic        [7:0]                    cell_index,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic        [7:0]                    read_index,
    input  logic signed [31:0]                   ez_value,
    input  logic signed [31:0]                   hy_value,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [fdtd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fdtd_pkg::INV_IMP_W-1:0]       cfg_data,
    output int                                   mismatches,
    output int                                   pending
);

    localparam longint HALF_LSB = 64'sd8388608;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] ez;
        logic [31:0] hy;
    } cell_read_t;

    logic signed [31:0]                   efield [fdtd_pkg::NCELLS];
    logic signed [31:0]                   hfield [fdtd_pkg::NCELLS];
    logic [fdtd_pkg::SRC_CELL_W-1:0]      src_cell;
    logic [fdtd_pkg::IMP_W-1:0]           imp;
    logic [fdtd_pkg::INV_IMP_W-1:0]       inv_imp;
    cell_read_t                           reads_due [$];
    int                                   fail_cnt;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // one leapfrog time step over the whole grid
    task automatic advance_grid(input logic signed [31:0] src);
        longint diff;
        longint inc;
        hfield[fdtd_pkg::NCELLS-1] = hfield[fdtd_pkg::NCELLS-2];
        for (int i = 0; i < fdtd_pkg::NCELLS - 1; i++)
        begin
            diff = longint'(efield[i+1]) - longint'(efield[i]);
            // q.48 product rounded to q8.24, ties upward
            inc = (diff * longint'(inv_imp) + HALF_LSB) >>> fdtd_pkg::FRAC_W;
            hfield[i] = clip32(longint'(hfield[i]) + inc);
        end
        efield[0] = efield[1];
        for (int i = 1; i < fdtd_pkg::NCELLS; i++)
        begin
            diff = longint'(hfield[i]) - longint'(hfield[i-1]);
            inc = diff * longint'(imp);
            efield[i] = clip32(longint'(efield[i]) + inc);
        end
        if (int'(src_cell) < fdtd_pkg::NCELLS)
        begin
            efield[src_cell] = clip32(longint'(efield[src_cell]) + longint'(src));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_read_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < fdtd_pkg::NCELLS; i++)
            begin
                efield[i] = '0;
                hfield[i] = '0;
            end
            src_cell = fdtd_pkg::SRC_CELL_RST;
            imp = fdtd_pkg::IMP_RST;
            inv_imp = fdtd_pkg::INV_IMP_RST;
            reads_due.delete();
            fail_cnt = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reads_due.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("%0t: unexpected result idx=%0d ez=%h hy=%h",
                                 $realtime, read_index, ez_value, hy_value);
                    end
                end
                else
                begin
                    want = reads_due.pop_front();
                    if ({read_index, ez_value, hy_value} !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display({"%0t: mismatch exp idx=%0d ez=%h hy=%h",
                                      " got idx=%0d ez=%h hy=%h"},
                                     $realtime, want.idx, want.ez, want.hy,
                                     read_index, ez_value, hy_value);
                        end
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fdtd_pkg::REG_SOURCE_CELL: src_cell = cfg_data[fdtd_pkg::SRC_CELL_W-1:0];
                    fdtd_pkg::REG_IMPEDANCE:   imp = cfg_data[fdtd_pkg::IMP_W-1:0];
                    fdtd_pkg::REG_INV_IMP:     inv_imp = cfg_data;
                    default:                   ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (cmd)
                begin
                    reads_due.push_back({cell_index, efield[cell_index], hfield[cell_index]});
                end
                else
                begin
                    advance_grid(source_value);
                end
            end

            mismatches <= fail_cnt;
            pending <= reads_due.size();
        end
    end

endmodule

>>> sim/tb_fdtd_1d_yee_grid_step_unit.sv
// testbench top for the yee grid step unit: clock, reset, stimulus, stall control and verdict
`timescale 1ns / 100ps
module tb_fdtd_1d_yee_grid_step_unit;

    localparam logic [fdtd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam int SETTLE_CYCLES  = 2 * fdtd_pkg::PASS_LEN + 64;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                cmd = CMD_STEP;
    logic signed [31:0]                  source_value = '0;
    logic        [7:0]                   cell_index = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic        [7:0]                   read_index;
    logic signed [31:0]                  ez_value;
    logic signed [31:0]                  hy_value;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [fdtd_pkg::CFG_IDX_W-1:0]      cfg_index = fdtd_pkg::REG_SOURCE_CELL;
    logic [fdtd_pkg::INV_IMP_W-1:0]      cfg_data = '0;

    int                                  mismatches;
    int                                  pending;
    int                                  tx_idle_pct = 0;
    int                                  rx_idle_pct = 0;
    logic                                pressure_on = 1'b0;
    int                                  hold_cnt = 0;
    int                                  quiet_cycles = 0;
    logic [7:0]                          src_target = fdtd_pkg::SRC_CELL_RST;
    logic [fdtd_pkg::IMP_W-1:0]          imp_pick;

    fdtd_1d_yee_grid_step_unit DUT (.*);

    fdtd_grid_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random stall, or one long hold-off while pressure is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (pressure_on && hold_cnt < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[fdtd_1d_yee_grid_step_unit] ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_source();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            return '0;
        end
        if (sel < 60)
        begin
            // within about plus or minus one in q8.24
            return 32'(int'($urandom_range(32'h0200_0000)) - 32'h0100_0000);
        end
        if (sel < 80)
        begin
            return 32'($urandom());
        end
        if (sel < 90)
        begin
            return 32'h7FFF_FFFF - 32'($urandom_range(3));
        end
        return 32'h8000_0000 + 32'($urandom_range(3));
    endfunction

    function automatic logic [7:0] pick_cell();
        if ($urandom_range(1) == 1)
        begin
            return 8'($urandom());
        end
        return src_target + 8'($urandom_range(16)) - 8'd8;
    endfunction

    task automatic send_item(input logic c, input logic signed [31:0] sv, input logic [7:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c;
        source_value <= sv;
        cell_index <= idx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // bursts of steps followed by reads, about half of them around the source
    task automatic send_random(input int count);
        int sent;
        int nsteps;
        int nreads;
        sent = 0;
        while (sent < count)
        begin
            nsteps = $urandom_range(0, 3);
            nreads = $urandom_range(1, 4);
            repeat (nsteps)
            begin
                send_item(CMD_STEP, pick_source(), 8'($urandom()));
                sent++;
            end
            repeat (nreads)
            begin
                send_item(CMD_READ, 32'($urandom()), pick_cell());
                sent++;
            end
        end
    endtask

    // waits out outstanding reads, then a settle time longer than a full step
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [fdtd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fdtd_pkg::INV_IMP_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty grid, extreme sources, rounding around zero, edge cells
        send_item(CMD_READ, 32'sh7FFF_FFFF, 8'd0);
        send_item(CMD_READ, 32'sh8000_0000, 8'd255);
        send_item(CMD_STEP, 32'sh7FFF_FFFF, 8'hFF);
        send_item(CMD_READ, '0, 8'd50);
        send_item(CMD_READ, '0, 8'd51);
        send_item(CMD_READ, '0, 8'd49);
        send_item(CMD_STEP, 32'sh8000_0000, 8'd0);
        send_item(CMD_STEP, 32'sh8000_0000, 8'hAA);
        send_item(CMD_READ, '0, 8'd50);
        send_item(CMD_STEP, 32'sd1, 8'd0);
        send_item(CMD_STEP, -32'sd1, 8'd0);
        send_item(CMD_STEP, '0, 8'd0);
        send_item(CMD_READ, '0, 8'd48);
        send_item(CMD_READ, '0, 8'd49);
        send_item(CMD_READ, '0, 8'd50);
        send_item(CMD_READ, '0, 8'd51);
        send_item(CMD_READ, '0, 8'd52);
        send_item(CMD_READ, '0, 8'd0);
        send_item(CMD_READ, '0, 8'd254);
        send_item(CMD_READ, '0, 8'd255);
        drain();

        // low extremes, upper data bits set to check they are dropped
        set_reg(fdtd_pkg::REG_SOURCE_CELL, 24'hFFFF00);
        set_reg(fdtd_pkg::REG_IMPEDANCE, 24'hFFFC01);
        set_reg(fdtd_pkg::REG_INV_IMP, 24'h000000);
        set_reg(REG_UNUSED, 24'h5A5A5A);
        src_target = 8'd0;
        tx_idle_pct = 23;
        rx_idle_pct <= 69;
        send_random(450);
        drain();

        // typical settings near a courant number of one
        src_target = 8'($urandom());
        imp_pick = 10'($urandom_range(2, 1023));
        set_reg(fdtd_pkg::REG_SOURCE_CELL, 24'(src_target));
        set_reg(fdtd_pkg::REG_IMPEDANCE, 24'(imp_pick));
        set_reg(fdtd_pkg::REG_INV_IMP, 24'(32'h0100_0000 / imp_pick));
        tx_idle_pct = 69;
        rx_idle_pct <= 23;
        send_random(450);
        drain();

        // high extremes, no idling, one long receiver hold-off in the middle
        set_reg(fdtd_pkg::REG_SOURCE_CELL, 24'h0000FF);
        set_reg(fdtd_pkg::REG_IMPEDANCE, 24'h0003FF);
        set_reg(fdtd_pkg::REG_INV_IMP, 24'hFFFFFF);
        src_target = 8'd255;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_random(100);
        pressure_on <= 1'b1;
        send_random(40);
        pressure_on <= 1'b0;
        send_random(130);
        drain();

        if (mismatches == 0 && pending == 0)
        begin
            $display("[fdtd_1d_yee_grid_step_unit] OK");
        end
        else
        begin
            $display("[fdtd_1d_yee_grid_step_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fdtd_pkg.sv
hw/rtl/fdtd_cell.sv
hw/rtl/fdtd_upd.sv
hw/rtl/fdtd_1d_yee_grid_step_unit.sv
sim/fdtd_grid_checker.sv
sim/tb_fdtd_1d_yee_grid_step_unit.sv
